@@ rtl/aqe_pkg.sv @@
`timescale 1ns / 1ps

package aqe_pkg;

    localparam int RUN_W = 6;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One classified item: everything the back end needs to expand it.
    typedef struct packed {
        logic             open_quote;
        logic             open_caret;
        logic [RUN_W-1:0] bs_count;
        logic             caret;
        logic [7:0]       final_byte;
        logic             ovf;
    } cmd_t;

    function automatic logic is_dangerous(input logic [7:0] b);
        logic hit;
        begin
            unique case (b)
                8'h5E, 8'h21, 8'h22, 8'h25, 8'h26,
                8'h28, 8'h29, 8'h3C, 8'h3E, 8'h7C: hit = 1'b1;
                default:                           hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

@@ rtl/aqe_front.sv @@
`timescale 1ns / 1ps

module aqe_front #(
    parameter int MAX_RUN = 60
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_bit,
    input  logic          in_fire,
    input  logic          kind,
    input  logic [7:0]    char_code,
    output aqe_pkg::cmd_t cmd
);

    localparam logic [aqe_pkg::RUN_W-1:0] RUN_LIMIT = aqe_pkg::RUN_W'(MAX_RUN);

    logic                      cmd_mode_reg;
    logic                      started_reg, started_next;
    logic [aqe_pkg::RUN_W-1:0] run_count_reg, run_count_next;
    logic                      overflow_seen_reg, overflow_seen_next;
    logic [aqe_pkg::RUN_W-1:0] run_eff;
    logic                      at_limit;

    always_comb
    begin
        run_eff  = started_reg ? run_count_reg : '0;
        at_limit = (run_eff >= RUN_LIMIT);

        cmd.open_quote = !started_reg;
        cmd.open_caret = !started_reg && cmd_mode_reg;
        cmd.bs_count   = '0;
        cmd.caret      = 1'b0;
        cmd.final_byte = char_code;
        cmd.ovf        = overflow_seen_reg;

        started_next       = 1'b1;
        run_count_next     = '0;
        overflow_seen_next = overflow_seen_reg;

        if (kind == aqe_pkg::KIND_END)
        begin
            // Double the pending run, then close the argument.
            cmd.bs_count       = run_eff;
            cmd.final_byte     = aqe_pkg::CH_QUOTE;
            cmd.caret          = cmd_mode_reg;
            started_next       = 1'b0;
            overflow_seen_next = 1'b0;
        end
        else if (char_code == aqe_pkg::CH_BACKSLASH)
        begin
            if (at_limit)
            begin
                run_count_next     = RUN_LIMIT;
                overflow_seen_next = 1'b1;
            end
            else
            begin
                run_count_next = run_eff + 1'b1;
            end
            cmd.ovf = overflow_seen_next;
        end
        else if (char_code == aqe_pkg::CH_QUOTE)
        begin
            cmd.bs_count = run_eff + 1'b1;
            cmd.caret    = cmd_mode_reg;
        end
        else
        begin
            cmd.caret = cmd_mode_reg && aqe_pkg::is_dangerous(char_code);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_mode_reg      <= 1'b0;
            started_reg       <= 1'b0;
            run_count_reg     <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cmd_mode_reg <= cfg_bit;
            end
            if (in_fire)
            begin
                started_reg       <= started_next;
                run_count_reg     <= run_count_next;
                overflow_seen_reg <= overflow_seen_next;
            end
        end
    end

endmodule

@@ rtl/aqe_queue.sv @@
`timescale 1ns / 1ps

module aqe_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  aqe_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output aqe_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    aqe_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/aqe_back.sv @@
`timescale 1ns / 1ps

module aqe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  aqe_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          last,
    output logic          overflow
);

    typedef enum logic [2:0] {
        PH_OPEN_CARET,
        PH_OPEN,
        PH_BS,
        PH_CARET,
        PH_BYTE
    } phase_t;

    aqe_pkg::cmd_t             cur_reg;
    logic                      busy_reg;
    phase_t                    phase_reg;
    logic [aqe_pkg::RUN_W-1:0] bs_left_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      last_reg;
    logic                      overflow_reg;

    logic                      emit;
    logic                      finishing;
    phase_t                    load_phase;
    phase_t                    after_open;
    phase_t                    after_bs;
    logic [7:0]                emit_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

    assign emit      = busy_reg && (!out_valid_reg || !out_stall);
    assign finishing = emit && (phase_reg == PH_BYTE);
    assign cmd_pop   = cmd_valid && (!busy_reg || finishing);

    always_comb
    begin
        after_bs   = cur_reg.caret ? PH_CARET : PH_BYTE;
        after_open = (cur_reg.bs_count != '0) ? PH_BS : after_bs;

        if (cmd.open_quote)
        begin
            load_phase = cmd.open_caret ? PH_OPEN_CARET : PH_OPEN;
        end
        else if (cmd.bs_count != '0)
        begin
            load_phase = PH_BS;
        end
        else
        begin
            load_phase = cmd.caret ? PH_CARET : PH_BYTE;
        end

        unique case (phase_reg)
            PH_OPEN_CARET: emit_byte = aqe_pkg::CH_CARET;
            PH_OPEN:       emit_byte = aqe_pkg::CH_QUOTE;
            PH_BS:         emit_byte = aqe_pkg::CH_BACKSLASH;
            PH_CARET:      emit_byte = aqe_pkg::CH_CARET;
            PH_BYTE:       emit_byte = cur_reg.final_byte;
            default:       emit_byte = cur_reg.final_byte;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            last_reg     <= (phase_reg == PH_BYTE);
            overflow_reg <= cur_reg.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_BYTE;
            bs_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd_pop)
            begin
                busy_reg    <= 1'b1;
                phase_reg   <= load_phase;
                bs_left_reg <= cmd.bs_count;
            end
            else if (finishing)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                unique case (phase_reg)
                    PH_OPEN_CARET: phase_reg <= PH_OPEN;
                    PH_OPEN:       phase_reg <= after_open;
                    PH_BS:
                    begin
                        bs_left_reg <= bs_left_reg - 1'b1;
                        if (bs_left_reg == aqe_pkg::RUN_W'(1))
                        begin
                            phase_reg <= after_bs;
                        end
                    end
                    PH_CARET:      phase_reg <= PH_BYTE;
                    default:       phase_reg <= PH_BYTE;
                endcase
            end
        end
    end

endmodule

@@ rtl/argument_quote_escaper_unit.sv @@
`timescale 1ns / 1ps

// Argument quote escaper: turns the bytes of one command-line argument into
// its quoted form, one output byte per transfer.
// Input channel: in_valid/in_stall with kind (0 = byte, 1 = end of argument)
// and char_code. Output channel: out_valid/out_stall with out_byte, last (set
// on the final byte of one input item) and overflow (backslash run clipped).
// Config channel: cfg_valid/cfg_ready, cfg_data bit 0 is cmd_mode; write it
// only while the block is idle. cfg_ready is always high.
// An input item is classified in the cycle it is taken and queued; the output
// sequencer then emits its 1 to 63 bytes at one byte per cycle while out_stall
// is low. The first byte passes through the queue, the sequencer's item register
// and the output register. Sustained throughput is one output byte per clock
// while out_stall is low; the output sequencer sets it.
// in_stall rises when the command queue is full. When out_stall is held, the
// output register and the sequencer hold, and intake stops once the queue
// fills. Reset clears cmd_mode, the argument state and the queue.
module argument_quote_escaper_unit #(
    parameter int MAX_RUN     = 60,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       overflow
);

    aqe_pkg::cmd_t front_cmd;
    aqe_pkg::cmd_t queue_cmd;
    logic          queue_full;
    logic          queue_valid;
    logic          queue_pop;
    logic          in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign in_fire   = in_valid && !queue_full;

    aqe_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_bit   (cfg_data[0]),
        .in_fire   (in_fire),
        .kind      (kind),
        .char_code (char_code),
        .cmd       (front_cmd)
    );

    aqe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_cmd)
    );

    aqe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .overflow  (overflow)
    );

endmodule

@@ dv/argument_quote_escaper_unit_tb.sv @@
`timescale 1ns / 1ps

module argument_quote_escaper_unit_tb;

    localparam int RUN_LIMIT   = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;

    localparam logic [7:0] SHELL_SET [10] = '{8'h5E, 8'h21, 8'h22, 8'h25, 8'h26,
                                              8'h28, 8'h29, 8'h3C, 8'h3E, 8'h7C};

    typedef struct {
        logic       kind;
        logic [7:0] code;
        int         gap;
    } arg_item_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       ovf;
    } quoted_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = aqe_pkg::KIND_BYTE;
    logic [7:0] char_code = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last;
    logic       overflow;

    arg_item_t    arg_q[$];
    quoted_byte_t quoted_q[$];

    // handshake results of the last rising edge, read at the falling edge
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic long_hold = 1'b0;
    logic quiet = 1'b0;

    // predictor state
    logic caret_mode = 1'b0;
    logic arg_open = 1'b0;
    int   bs_run = 0;
    logic run_clipped = 1'b0;

    int gap_count = 0;
    int out_wait = 0;
    int hold_left = 0;
    int next_hold_at = 70;
    int cycles = 0;
    int errors = 0;
    int items_pushed = 0;
    int items_taken = 0;
    int bytes_checked = 0;
    int ovf_bytes = 0;
    int carets_seen = 0;
    int mode_writes = 0;
    logic saw_backpressure = 1'b0;

    argument_quote_escaper_unit #(
        .MAX_RUN(RUN_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .char_code(char_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last(last),
        .overflow(overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("argument_quote_escaper_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= 50)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic logic shell_special(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        foreach (SHELL_SET[i])
            if (b == SHELL_SET[i])
                hit = 1'b1;
        return hit;
    endfunction

    task automatic put_text(ref logic [7:0] seq[$], input logic [7:0] b);
        if (caret_mode && shell_special(b))
            seq.insert(seq.size(), aqe_pkg::CH_CARET);
        seq.insert(seq.size(), b);
    endtask

    // expand one input transfer into the quoted bytes it must produce
    task automatic quote_item(input logic k, input logic [7:0] c);
        logic [7:0]   seq[$];
        logic         ovf_now;
        quoted_byte_t qb;
        if (!arg_open)
        begin
            put_text(seq, aqe_pkg::CH_QUOTE);
            arg_open = 1'b1;
            bs_run = 0;
        end
        if (k == aqe_pkg::KIND_END)
        begin
            repeat (bs_run) seq.insert(seq.size(), aqe_pkg::CH_BACKSLASH);
            put_text(seq, aqe_pkg::CH_QUOTE);
            ovf_now = run_clipped;
            arg_open = 1'b0;
            bs_run = 0;
            run_clipped = 1'b0;
        end
        else
        begin
            if (c == aqe_pkg::CH_BACKSLASH)
            begin
                seq.insert(seq.size(), c);
                if (bs_run >= RUN_LIMIT)
                begin
                    bs_run = RUN_LIMIT;
                    run_clipped = 1'b1;
                end
                else
                    bs_run++;
            end
            else if (c == aqe_pkg::CH_QUOTE)
            begin
                repeat (bs_run + 1) seq.insert(seq.size(), aqe_pkg::CH_BACKSLASH);
                put_text(seq, c);
                bs_run = 0;
            end
            else
            begin
                put_text(seq, c);
                bs_run = 0;
            end
            ovf_now = run_clipped;
        end
        foreach (seq[i])
        begin
            qb.text = seq[i];
            qb.last = (i == seq.size() - 1);
            qb.ovf  = ovf_now;
            quoted_q.insert(quoted_q.size(), qb);
        end
    endtask

    // monitor: sample every transfer at the rising edge
    always @(posedge clk)
    begin
        quoted_byte_t want;
        in_taken  <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (long_hold && in_stall)
                saw_backpressure = 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                caret_mode = cfg_data[0];
                mode_writes++;
            end
            if (in_valid && !in_stall)
            begin
                quote_item(kind, char_code);
                items_taken++;
            end
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (overflow)
                    ovf_bytes++;
                if (out_byte == aqe_pkg::CH_CARET)
                    carets_seen++;
                if (quoted_q.size() == 0)
                    flag_mismatch($sformatf("unexpected byte %02h", out_byte));
                else
                begin
                    want = quoted_q.pop_front();
                    if (out_byte !== want.text)
                        flag_mismatch($sformatf("out_byte %02h, want %02h",
                                                out_byte, want.text));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last %b, want %b (byte %02h)",
                                                last, want.last, want.text));
                    if (overflow !== want.ovf)
                        flag_mismatch($sformatf("overflow %b, want %b (byte %02h)",
                                                overflow, want.ovf, want.text));
                end
            end
        end
    end

    // input driver: hold the item until taken, then wait its gap and offer the next
    always @(negedge clk)
    begin
        arg_item_t cur;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (arg_q.size() == 0)
                in_valid <= 1'b0;
            else if (gap_count < arg_q[0].gap)
            begin
                gap_count++;
                in_valid <= 1'b0;
            end
            else
            begin
                cur = arg_q.pop_front();
                gap_count = 0;
                in_valid  <= 1'b1;
                kind      <= cur.kind;
                char_code <= cur.code;
            end
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (items_taken >= next_hold_at)
        begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 120;
        end
        long_hold <= (hold_left != 0);
    end

    // output receiver: draw a stall length after every transfer
    always @(negedge clk)
    begin
        if (out_taken)
            out_wait = quiet ? 0 : $urandom_range(0, 13);
        else if (out_wait > 0)
            out_wait--;
        out_stall <= long_hold || (out_wait != 0);
    end

    task automatic push_item(input logic k, input logic [7:0] c);
        arg_item_t it;
        it.kind = k;
        it.code = c;
        it.gap  = quiet ? 0 : $urandom_range(0, 13);
        arg_q.insert(arg_q.size(), it);
        items_pushed++;
    endtask

    task automatic push_run(input int n);
        repeat (n) push_item(aqe_pkg::KIND_BYTE, aqe_pkg::CH_BACKSLASH);
    endtask

    // one well-formed argument with random content; sometimes left open
    task automatic queue_argument(input logic long_run);
        int n;
        int r;
        n = $urandom_range(0, 10);
        if (long_run || $urandom_range(0, 19) == 0)
            push_run($urandom_range(RUN_LIMIT - 2, RUN_LIMIT + 4));
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                push_run($urandom_range(1, 3));
            else if (r < 50)
                push_item(aqe_pkg::KIND_BYTE, aqe_pkg::CH_QUOTE);
            else if (r < 65)
                push_item(aqe_pkg::KIND_BYTE, SHELL_SET[$urandom_range(0, 9)]);
            else
                push_item(aqe_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            push_item(aqe_pkg::KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        while (items_taken != items_pushed || quoted_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_cmd_mode(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int   target;
        logic modes [4];
        modes = '{1'b0, 1'b1, 1'b1, 1'b0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // plain mode: empty argument, byte extremes, runs before quote and end
        push_item(aqe_pkg::KIND_END, 8'hFF);
        push_item(aqe_pkg::KIND_BYTE, 8'h61);
        push_item(aqe_pkg::KIND_BYTE, 8'h00);
        push_item(aqe_pkg::KIND_BYTE, 8'hFF);
        push_item(aqe_pkg::KIND_END, 8'h00);
        push_run(2);
        push_item(aqe_pkg::KIND_BYTE, aqe_pkg::CH_QUOTE);
        push_item(aqe_pkg::KIND_END, 8'h5C);
        push_run(2);
        push_item(aqe_pkg::KIND_END, 8'h22);
        // leave an argument open across the mode change
        push_item(aqe_pkg::KIND_BYTE, 8'h78);
        drain();
        set_cmd_mode(1'b1);

        foreach (SHELL_SET[i])
            push_item(aqe_pkg::KIND_BYTE, SHELL_SET[i]);
        push_item(aqe_pkg::KIND_END, 8'h7C);
        push_run(1);
        push_item(aqe_pkg::KIND_END, 8'hA5);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_cmd_mode(modes[ph]);
            quiet  = (ph == 2);
            target = items_pushed + 55;
            queue_argument(ph == 1);
            while (items_pushed < target)
            begin
                // a little noise: any kind, any byte
                if ($urandom_range(0, 9) == 0)
                    push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                else
                    queue_argument(1'b0);
            end
            drain();
        end
        quiet = 1'b0;

        if (quoted_q.size() != 0)
            flag_mismatch($sformatf("%0d expected bytes never arrived", quoted_q.size()));
        $display("covered %0d input transfers, %0d output bytes (%0d flagged overflow, %0d carets)",
                 items_taken, bytes_checked, ovf_bytes, carets_seen);
        $display("%0d mode writes; input stalled under long output hold-off: %s",
                 mode_writes, saw_backpressure ? "yes" : "no");
        if (errors == 0)
            $display("argument_quote_escaper_unit_tb OK");
        else
            $display("argument_quote_escaper_unit_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/aqe_pkg.sv
rtl/aqe_front.sv
rtl/aqe_queue.sv
rtl/aqe_back.sv
rtl/argument_quote_escaper_unit.sv
dv/argument_quote_escaper_unit_tb.sv
